[hdl/pascal_keyword_recognizer_defines.svh]
// Assertion macros for the Pascal keyword recogniser.
// Used by the top level; clocked on clk_i and disabled while rst_ni is low.
`ifndef PASCAL_KEYWORD_RECOGNIZER_DEFINES_SVH
`define PASCAL_KEYWORD_RECOGNIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define PKR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PKR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PKR_ASSERT_IMP(lbl, ante, cons, msg)
`define PKR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/pkr_pkg.sv]
// Shared types, constants and the reserved-word table of the keyword recogniser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pkr_pkg;

  localparam int TOK_LEN  = 8;
  localparam int IDX_W    = $clog2(TOK_LEN);
  localparam int FILL_W   = $clog2(TOK_LEN + 1);
  localparam int KW_COUNT = 43;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CASE_BIT      = 8'h20;
  localparam logic [3:0] NO_OPERATOR   = 4'd15;
  localparam logic [5:0] CLASS_IDENT   = 6'd0;

  typedef struct packed {
    logic       skip;
    logic       store;
    logic       term;
    logic [7:0] upper;
  } char_class_t;

  // Words are held with the first character in the most significant byte.
  typedef struct packed {
    logic [63:0] word;
    logic [5:0]  cls;
    logic [3:0]  opc;
  } kw_entry_t;

  localparam kw_entry_t KW_ROM [KW_COUNT] = '{
    '{"AND     ", 6'd39, 4'd2},  '{"ARRAY   ", 6'd44, 4'd15}, '{"BEGIN   ", 6'd19, 4'd15},
    '{"CASE    ", 6'd21, 4'd15}, '{"CONST   ", 6'd28, 4'd15}, '{"DIV     ", 6'd39, 4'd3},
    '{"DO      ", 6'd6, 4'd15},  '{"DOWNTO  ", 6'd8, 4'd15},  '{"ELSE    ", 6'd13, 4'd15},
    '{"END     ", 6'd9, 4'd15},  '{"EXTERNAL", 6'd53, 4'd15}, '{"FILE    ", 6'd46, 4'd15},
    '{"FOR     ", 6'd24, 4'd15}, '{"FORWARD ", 6'd34, 4'd15}, '{"FUNCTION", 6'd32, 4'd15},
    '{"GOTO    ", 6'd26, 4'd15}, '{"IF      ", 6'd20, 4'd15}, '{"IMPLEMEN", 6'd52, 4'd15},
    '{"IN      ", 6'd41, 4'd14}, '{"INTERFAC", 6'd51, 4'd15}, '{"LABEL   ", 6'd27, 4'd15},
    '{"MOD     ", 6'd39, 4'd4},  '{"NOT     ", 6'd38, 4'd15}, '{"OF      ", 6'd11, 4'd15},
    '{"OR      ", 6'd40, 4'd7},  '{"OTHERWIS", 6'd55, 4'd15}, '{"PACKED  ", 6'd43, 4'd15},
    '{"PROCEDUR", 6'd31, 4'd15}, '{"PROGRAM ", 6'd33, 4'd15}, '{"RECORD  ", 6'd45, 4'd15},
    '{"REPEAT  ", 6'd22, 4'd15}, '{"SEGMENT ", 6'd33, 4'd15}, '{"SEPARATE", 6'd54, 4'd15},
    '{"SET     ", 6'd42, 4'd15}, '{"THEN    ", 6'd12, 4'd15}, '{"TO      ", 6'd7, 4'd15},
    '{"TYPE    ", 6'd29, 4'd15}, '{"UNIT    ", 6'd50, 4'd15}, '{"UNTIL   ", 6'd10, 4'd15},
    '{"USES    ", 6'd49, 4'd15}, '{"VAR     ", 6'd30, 4'd15}, '{"WHILE   ", 6'd23, 4'd15},
    '{"WITH    ", 6'd25, 4'd15}
  };

endpackage

`default_nettype wire

[hdl/pkr_token_acc.sv]
// Character classification and token accumulator: eight token bytes, fill and
// character counts. Depends on pkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkr_token_acc
  import pkr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        ch_i,
  output char_class_t            cls_o,
  output logic [63:0]            token_o,
  output logic [15:0]            consumed_o,
  output logic [FILL_W-1:0]      fill_o
);

  logic [7:0]        tok_q [TOK_LEN];
  logic [FILL_W-1:0] fill_q;
  logic [15:0]       cnt_q;
  logic [7:0]        folded;

  always_comb begin
    folded = ch_i;
    if (ch_i inside {[8'h61:8'h7A]}) begin
      folded = ch_i & ~CASE_BIT;
    end
    cls_o.upper = folded;
    cls_o.skip  = (ch_i == CH_UNDERSCORE);
    cls_o.store = (folded inside {[8'h41:8'h5A], [8'h30:8'h39]});
    cls_o.term  = !cls_o.skip && !cls_o.store;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOK_LEN; i++) begin
        tok_q[i] <= CH_SPACE;
      end
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      if (cls_o.term) begin
        for (int i = 0; i < TOK_LEN; i++) begin
          tok_q[i] <= CH_SPACE;
        end
        fill_q <= '0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + 16'd1;
        if (cls_o.store && (fill_q < FILL_W'(TOK_LEN))) begin
          tok_q[fill_q[IDX_W-1:0]] <= cls_o.upper;
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TOK_LEN; i++) begin
      token_o[8*i +: 8] = tok_q[i];
    end
  end

  assign consumed_o = cnt_q;
  assign fill_o     = fill_q;

endmodule

`default_nettype wire

[hdl/pkr_kw_match.sv]
// Parallel compare of the token against the reserved-word table.
// Depends on pkr_pkg for the table and the no-operator code.
`timescale 1ns / 1ps
`default_nettype none

module pkr_kw_match
  import pkr_pkg::*;
(
  input  wire logic [63:0] token_i,
  output logic [5:0]       cls_o,
  output logic [3:0]       opc_o,
  output logic             found_o
);

  logic [63:0] tok_rev;

  always_comb begin
    for (int i = 0; i < TOK_LEN; i++) begin
      tok_rev[8*(TOK_LEN-1-i) +: 8] = token_i[8*i +: 8];
    end
  end

  // The table holds each word once, so at most one entry can hit.
  always_comb begin
    cls_o   = CLASS_IDENT;
    opc_o   = NO_OPERATOR;
    found_o = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (tok_rev == KW_ROM[k].word) begin
        cls_o   = KW_ROM[k].cls;
        opc_o   = KW_ROM[k].opc;
        found_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/pascal_keyword_recognizer.sv]
// Top level of the Pascal keyword recogniser: input register, token
// accumulator, table match and result register. Depends on pkr_pkg,
// pkr_token_acc, pkr_kw_match and pascal_keyword_recognizer_defines.svh.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    ch_i
//   out      source     out_valid_o / out_stall_i  symbol_class_o, operator_code_o,
//                                                  found_o, token_text_o, chars_consumed_o
//
// One character is accepted per cycle while in_stall_o is low; a result passes
// from its terminating character through the input register and the result
// register. Reset clears the token to spaces and both counts to zero.
// While a result waits under out_stall_i, a further terminator holds in the
// input register and in_stall_o rises; letters, digits and underscores go on.
`timescale 1ns / 1ps
`default_nettype none
`include "pascal_keyword_recognizer_defines.svh"

module pascal_keyword_recognizer
  import pkr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       symbol_class_o,
  output logic [3:0]       operator_code_o,
  output logic             found_o,
  output logic [63:0]      token_text_o,
  output logic [15:0]      chars_consumed_o
);

  logic              in_valid_q;
  logic [7:0]        ch_q;
  logic              advance;
  char_class_t       cls;
  logic [63:0]       token;
  logic [15:0]       consumed;
  logic [FILL_W-1:0] fill;
  logic [5:0]        m_cls;
  logic [3:0]        m_opc;
  logic              m_found;
  logic              out_valid_q;
  logic [5:0]        cls_q;
  logic [3:0]        opc_q;
  logic              found_q;
  logic [63:0]       text_q;
  logic [15:0]       count_q;

  assign advance    = in_valid_q && (!cls.term || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q <= ch_i;
    end
  end

  pkr_token_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .ch_i       (ch_q),
    .cls_o      (cls),
    .token_o    (token),
    .consumed_o (consumed),
    .fill_o     (fill)
  );

  pkr_kw_match u_match (
    .token_i (token),
    .cls_o   (m_cls),
    .opc_o   (m_opc),
    .found_o (m_found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && cls.term) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cls.term) begin
      cls_q   <= m_cls;
      opc_q   <= m_opc;
      found_q <= m_found;
      text_q  <= token;
      count_q <= consumed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_class_o   = cls_q;
  assign operator_code_o  = opc_q;
  assign found_o          = found_q;
  assign token_text_o     = text_q;
  assign chars_consumed_o = count_q;

  `PKR_ASSERT_IMP(a_fill_bound, 1'b1, fill <= FILL_W'(TOK_LEN),
                  "token fill count exceeds eight")
  `PKR_ASSERT_NXT(a_clear_on_term, advance && cls.term,
                  fill == '0 && consumed == 16'd0,
                  "accumulator not cleared after a terminator")
  `PKR_ASSERT_IMP(a_nomatch_code, out_valid_o && !found_o,
                  symbol_class_o == CLASS_IDENT && operator_code_o == NO_OPERATOR,
                  "unmatched result carries a keyword code")
  `PKR_ASSERT_IMP(a_stall_only_term, in_stall_o, in_valid_q && cls.term && out_valid_q,
                  "input stalled without a waiting terminator")

endmodule

`default_nettype wire
